### hdl/rpc_pkg.sv
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int IN_W          = 4;
  localparam int CNT_W         = 63;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // row sum and token handed from one column cell to the next
  typedef struct packed {
    logic             token;
    logic             origin;
    logic             ovf;
    logic [CNT_W-1:0] rsum;
    logic [CNT_W-1:0] cnt;
  } link_t;

endpackage

### hdl/rpc_cell.sv
`timescale 1ns / 1ps

module rpc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  rpc_pkg::link_t link_in,
  output rpc_pkg::link_t link_out
);

  logic [rpc_pkg::CNT_W-1:0] col_sum;
  logic [rpc_pkg::CNT_W+1:0] s_cell;
  logic [rpc_pkg::CNT_W+1:0] s_row;
  logic [rpc_pkg::CNT_W+1:0] s_col;
  logic [rpc_pkg::CNT_W-1:0] cell_next;
  logic [rpc_pkg::CNT_W-1:0] rsum_next;
  logic [rpc_pkg::CNT_W-1:0] col_next;
  logic                      ovf_next;

  // cell = r + c, row sum = 2r + c, column sum = r + 2c, all saturating; all 1 at the origin
  always_comb begin
    s_cell = {2'b00, link_in.rsum} + {2'b00, col_sum};
    s_row  = {1'b0, link_in.rsum, 1'b0} + {2'b00, col_sum};
    s_col  = {2'b00, link_in.rsum} + {1'b0, col_sum, 1'b0};
    if (link_in.origin) begin
      cell_next = rpc_pkg::CNT_W'(1);
      rsum_next = rpc_pkg::CNT_W'(1);
      col_next  = rpc_pkg::CNT_W'(1);
      ovf_next  = link_in.ovf;
    end else begin
      cell_next = (s_cell[rpc_pkg::CNT_W+1:rpc_pkg::CNT_W] != 2'b00) ?
                  rpc_pkg::COUNT_MAX : s_cell[rpc_pkg::CNT_W-1:0];
      rsum_next = (s_row[rpc_pkg::CNT_W+1:rpc_pkg::CNT_W] != 2'b00) ?
                  rpc_pkg::COUNT_MAX : s_row[rpc_pkg::CNT_W-1:0];
      col_next  = (s_col[rpc_pkg::CNT_W+1:rpc_pkg::CNT_W] != 2'b00) ?
                  rpc_pkg::COUNT_MAX : s_col[rpc_pkg::CNT_W-1:0];
      ovf_next  = link_in.ovf
                  || (s_row[rpc_pkg::CNT_W+1:rpc_pkg::CNT_W] != 2'b00)
                  || (s_col[rpc_pkg::CNT_W+1:rpc_pkg::CNT_W] != 2'b00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      link_out.token <= 1'b0;
    end else begin
      link_out.token <= link_in.token;
    end
    if (clear) begin
      col_sum <= '0;
    end else if (link_in.token) begin
      col_sum         <= col_next;
      link_out.origin <= 1'b0;
      link_out.ovf    <= ovf_next;
      link_out.rsum   <= rsum_next;
      link_out.cnt    <= cell_next;
    end
  end

endmodule

### hdl/rook_path_counter.sv
`timescale 1ns / 1ps
// The target row and col are clamped to GRID_SIZE - 1.
// One request at a time: a token walks the column cells, one cell a cycle,
// once per row. A new request is taken from the cycle after the result is
// accepted on m_tready.
// Reset (rst, synchronous) returns the control to idle and drops any token.

module rook_path_counter #(
  parameter int GRID_SIZE = rpc_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // row_index[3:0], col_index[7:4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // path_count[62:0], saturated[63]
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [6:0] MAX_IDX = 7'(GRID_SIZE - 1);

  typedef enum logic [1:0] {S_IDLE, S_KICK, S_WAIT, S_OUT} state_t;

  state_t     state;
  logic [IDX_W-1:0] tr;
  logic [IDX_W-1:0] tc;
  logic [IDX_W-1:0] row;
  logic             ovf;
  logic [IDX_W-1:0] tr_next;
  logic [IDX_W-1:0] tc_next;
  logic [6:0]       row_ext;
  logic [6:0]       col_ext;
  logic             accept;
  logic             row_done;
  rpc_pkg::link_t   tail;

  rpc_pkg::link_t chain_in [GRID_SIZE];
  rpc_pkg::link_t links    [GRID_SIZE];
  logic [GRID_SIZE-1:0] tokens;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    row_ext = {3'b000, s_tdata[3:0]};
    col_ext = {3'b000, s_tdata[7:4]};
    if (row_ext > MAX_IDX) row_ext = MAX_IDX;
    if (col_ext > MAX_IDX) col_ext = MAX_IDX;
    tr_next = row_ext[IDX_W-1:0];
    tc_next = col_ext[IDX_W-1:0];
  end

  always_comb begin
    chain_in[0].token  = (state == S_KICK);
    chain_in[0].origin = (row == '0);
    chain_in[0].ovf    = ovf;
    chain_in[0].rsum   = '0;
    chain_in[0].cnt    = '0;
  end

  genvar i;
  generate
    for (i = 0; i < GRID_SIZE; i++) begin : g_cell
      if (i > 0) begin : g_link
        always_comb begin
          chain_in[i]       = links[i-1];
          chain_in[i].token = links[i-1].token && (tc != IDX_W'(i - 1));
        end
      end
      rpc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (accept),
        .link_in  (chain_in[i]),
        .link_out (links[i])
      );
      assign tokens[i] = links[i].token;
    end
  endgenerate

  assign tail     = links[tc];
  assign row_done = (state == S_WAIT) && tail.token;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
      ovf      <= 1'b0;
      row      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          s_tready <= 1'b1;
          if (accept) begin
            tr       <= tr_next;
            tc       <= tc_next;
            row      <= '0;
            ovf      <= 1'b0;
            s_tready <= 1'b0;
            state    <= S_KICK;
          end
        end
        S_KICK: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (row_done) begin
            ovf <= tail.ovf;
            if (row == tr) begin
              m_tdata  <= {tail.ovf, tail.cnt};
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else begin
              row   <= row + 1'b1;
              state <= S_KICK;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tokens))
    else $error("more than one token in the cell chain");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("request taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
    else $error("block not busy after a request");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (row <= tr))
    else $error("row counter past target");

endmodule
